FILE: design/aesiks_pkg.sv
// Package for the AES-128 inverse key schedule: S-box table, round constants,
// byte-datapath control struct. No dependencies.
`default_nettype none

package aesiks_pkg;

   localparam int KEY_BYTES = 16;
   localparam logic [3:0] ROUNDS = 4'd10;
   localparam logic [3:0] BYTE_LAST = 4'd15;
   localparam logic [3:0] BYTE_SUB_FIRST = 4'd12;

   localparam logic [7:0] SBOX_TAB [256] = '{
      8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5,
      8'h30, 8'h01, 8'h67, 8'h2B, 8'hFE, 8'hD7, 8'hAB, 8'h76,
      8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
      8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0,
      8'hB7, 8'hFD, 8'h93, 8'h26, 8'h36, 8'h3F, 8'hF7, 8'hCC,
      8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
      8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A,
      8'h07, 8'h12, 8'h80, 8'hE2, 8'hEB, 8'h27, 8'hB2, 8'h75,
      8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
      8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84,
      8'h53, 8'hD1, 8'h00, 8'hED, 8'h20, 8'hFC, 8'hB1, 8'h5B,
      8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
      8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85,
      8'h45, 8'hF9, 8'h02, 8'h7F, 8'h50, 8'h3C, 8'h9F, 8'hA8,
      8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
      8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2,
      8'hCD, 8'h0C, 8'h13, 8'hEC, 8'h5F, 8'h97, 8'h44, 8'h17,
      8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88,
      8'h46, 8'hEE, 8'hB8, 8'h14, 8'hDE, 8'h5E, 8'h0B, 8'hDB,
      8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
      8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79,
      8'hE7, 8'hC8, 8'h37, 8'h6D, 8'h8D, 8'hD5, 8'h4E, 8'hA9,
      8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
      8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6,
      8'hE8, 8'hDD, 8'h74, 8'h1F, 8'h4B, 8'hBD, 8'h8B, 8'h8A,
      8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
      8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E,
      8'hE1, 8'hF8, 8'h98, 8'h11, 8'h69, 8'hD9, 8'h8E, 8'h94,
      8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
      8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2D, 8'h0F, 8'hB0, 8'h54, 8'hBB, 8'h16
   };

   // round constant for the n-th backward round (n = 0 undoes round 10)
   function automatic logic [7:0] rcon_down(input logic [3:0] n);
      logic [7:0] rc;
      case (n)
         4'd0: rc = 8'h36;
         4'd1: rc = 8'h1B;
         4'd2: rc = 8'h80;
         4'd3: rc = 8'h40;
         4'd4: rc = 8'h20;
         4'd5: rc = 8'h10;
         4'd6: rc = 8'h08;
         4'd7: rc = 8'h04;
         4'd8: rc = 8'h02;
         4'd9: rc = 8'h01;
         default: rc = 8'h00;
      endcase
      return rc;
   endfunction

   typedef struct packed {
      logic       load;     // parallel load of a new key
      logic       shift;    // rotate one byte through the update logic
      logic       sub_en;   // bytes 3..0: xor in S-box of the new last word
      logic       tap_far;  // byte 3 takes its S-box input from the far tap
      logic       rc_en;    // byte 0: xor in the round constant
      logic [7:0] rc;
   } ctrl_type;

endpackage

`default_nettype wire

FILE: design/aesiks_byte_ring.sv
// Byte-serial key ring for the inverse key schedule: 16-byte rotating
// shift register with the one-byte update at its head. Uses aesiks_pkg.
`default_nettype none

module aesiks_byte_ring (
   input  wire logic               clock,
   input  wire aesiks_pkg::ctrl_type ctrl,
   input  wire logic [127:0]       load_key,
   output logic [127:0]            key
);

   // sr_ff[m] holds key byte 15-m; the head sr_ff[0] is updated each shift
   logic [7:0] sr_ff [aesiks_pkg::KEY_BYTES];
   logic [7:0] sr_in [aesiks_pkg::KEY_BYTES];
   logic [7:0] sub_tap;
   logic [7:0] new_byte;

   always_comb begin
      sub_tap = ctrl.tap_far ? sr_ff[7] : sr_ff[3];
      if (ctrl.sub_en) begin
         new_byte = sr_ff[0] ^ aesiks_pkg::SBOX_TAB[sub_tap] ^ (ctrl.rc_en ? ctrl.rc : 8'h00);
      end else begin
         new_byte = sr_ff[0] ^ sr_ff[4];
      end
   end

   always_comb begin
      for (int m = 0; m < aesiks_pkg::KEY_BYTES; m++) begin
         if (ctrl.load) begin
            sr_in[m] = load_key[8*m +: 8];
         end else if (ctrl.shift) begin
            sr_in[m] = (m == aesiks_pkg::KEY_BYTES - 1) ? new_byte : sr_ff[(m + 1) % 16];
         end else begin
            sr_in[m] = sr_ff[m];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int m = 0; m < aesiks_pkg::KEY_BYTES; m++) begin
         sr_ff[m] <= sr_in[m];
      end
   end

   always_comb begin
      for (int m = 0; m < aesiks_pkg::KEY_BYTES; m++) begin
         key[8*m +: 8] = sr_ff[m];
      end
   end

endmodule

`default_nettype wire

FILE: design/aes128_inverse_key_schedule_top.sv
// Top level of the AES-128 inverse key schedule: control sequencer, config
// register and output register. Uses aesiks_pkg and aesiks_byte_ring.
`default_nettype none

// Usage
//   Request channel (req_valid / req_stall): a round-10 key as req_key_hi and
//   req_key_lo, byte 0 in bits 63:56 of req_key_hi. A request is taken at a
//   clock edge with req_valid high and req_stall low.
//   Response channel (rsp_valid / rsp_stall): the round key selected by the
//   target_round register, in the same byte order.
//   Config: csr_wr_en with csr_wr_data writes target_round (0 = cipher key).
//   Values above ten run no backward rounds and return the input key.
// Operation
//   Each backward round rotates the 16-byte key ring once, one byte per
//   cycle. With n = 10 - target_round rounds (n = 0 for target_round >= 10),
//   the ring runs n full rotations after the request is taken, then the
//   result moves to the output register; only then can the next request be
//   taken, so a new key waits until the last one has left the ring.
// Stall
//   The result sits in an output register. While it waits on rsp_stall the
//   next request runs; if that one finishes first it waits in the ring until
//   the output register frees, and req_stall stays high meanwhile.
// Reset
//   Synchronous: clears the sequencer, the output valid and target_round.

module aes128_inverse_key_schedule_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_key_hi,
   input  wire logic [63:0] req_key_lo,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_out_hi,
   output logic [63:0]      rsp_out_lo,
   input  wire logic        csr_wr_en,
   input  wire logic [3:0]  csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [3:0] byte_cnt_ff, byte_cnt_in;
   logic [3:0] round_cnt_ff, round_cnt_in;
   logic [3:0] steps_ff, steps_in;
   logic [3:0] target_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_hi_ff, rsp_lo_ff;

   logic       req_accept;
   logic       rsp_free;
   logic       last_byte;
   logic       xfer;
   logic [3:0] steps_calc;
   logic [127:0] ring_key;
   aesiks_pkg::ctrl_type ctrl;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign last_byte  = (byte_cnt_ff == aesiks_pkg::BYTE_LAST);
   assign xfer       = (state_ff == ST_DONE) && rsp_free;
   assign steps_calc = (target_ff <= aesiks_pkg::ROUNDS) ?
                       (aesiks_pkg::ROUNDS - target_ff) : 4'd0;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      byte_cnt_in  = byte_cnt_ff;
      round_cnt_in = round_cnt_ff;
      steps_in     = steps_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               byte_cnt_in  = 4'd0;
               round_cnt_in = 4'd0;
               steps_in     = steps_calc;
               state_in     = (steps_calc == 4'd0) ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            byte_cnt_in = byte_cnt_ff + 4'd1;
            if (last_byte) begin
               round_cnt_in = round_cnt_ff + 4'd1;
               if (round_cnt_ff + 4'd1 == steps_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // byte ring control: bytes 15..4 fold in the word below, bytes 3..0
   // fold in the S-box of the rotated new top word
   always_comb begin
      ctrl.load    = req_accept;
      ctrl.shift   = (state_ff == ST_RUN);
      ctrl.sub_en  = byte_cnt_ff inside {[aesiks_pkg::BYTE_SUB_FIRST:aesiks_pkg::BYTE_LAST]};
      ctrl.tap_far = (byte_cnt_ff == aesiks_pkg::BYTE_SUB_FIRST);
      ctrl.rc_en   = last_byte;
      ctrl.rc      = aesiks_pkg::rcon_down(round_cnt_ff);
   end

   aesiks_byte_ring u_ring (
      .clock    (clock),
      .ctrl     (ctrl),
      .load_key ({req_key_hi, req_key_lo}),
      .key      (ring_key)
   );

   // output register
   always_comb begin
      if (xfer) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         byte_cnt_ff  <= 4'd0;
         round_cnt_ff <= 4'd0;
         steps_ff     <= 4'd0;
         target_ff    <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         byte_cnt_ff  <= byte_cnt_in;
         round_cnt_ff <= round_cnt_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            target_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (xfer) begin
         rsp_hi_ff <= ring_key[127:64];
         rsp_lo_ff <= ring_key[63:0];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_hi = rsp_hi_ff;
   assign rsp_out_lo = rsp_lo_ff;

endmodule

`default_nettype wire

FILE: design/aesiks_checker.sv
// Port-level checker for aes128_inverse_key_schedule_top, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module aesiks_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [63:0] rsp_out_hi,
   input wire logic [63:0] rsp_out_lo
);

   // reset empties the output register
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a taken request leaves the block busy in the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("req_stall low right after a request was taken");

   // a new response appears only as the sequencer returns to idle
   a_rsp_with_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("response appeared while the block stayed busy");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_out_hi) && $stable(rsp_out_lo)))
      else $error("stalled response changed");

endmodule

bind aes128_inverse_key_schedule_top aesiks_checker u_aesiks_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_out_hi (rsp_out_hi),
   .rsp_out_lo (rsp_out_lo)
);

`default_nettype wire

FILE: dv/aes128_inverse_key_schedule_checker.sv
// Checker for the AES-128 inverse key schedule: watches the request, response
// and config ports, predicts each recovered round key and compares it.
// Standalone; needs no package.
`default_nettype none

module aes128_inverse_key_schedule_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [63:0] req_key_hi,
   input  wire logic [63:0] req_key_lo,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [63:0] rsp_out_hi,
   input  wire logic [63:0] rsp_out_lo,
   input  wire logic        csr_wr_en,
   input  wire logic [3:0]  csr_wr_data,
   output int               mismatches,
   output int               outstanding
);

   localparam int LAST_ROUND   = 10;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [63:0] hi;
      logic [63:0] lo;
   } round_key_t;

   logic [7:0] sbox_lut [256];
   round_key_t expected_keys [$];
   round_key_t want;
   round_key_t known_answer;
   logic [3:0] target_round;
   logic       known_bad = 1'b0;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] x;
      acc = 8'h00;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= x;
         x = xtime(x);
      end
      return acc;
   endfunction

   // S-box from its definition: field inverse, then the affine map
   function automatic logic [7:0] sbox_of(input logic [7:0] v);
      logic [7:0] b;
      b = 8'h00;
      for (int i = 1; i < 256; i++)
         if (gf_mul(v, i[7:0]) == 8'h01) b = i[7:0];
      return b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
             ^ {b[3:0], b[7:4]} ^ 8'h63;
   endfunction

   // constant of forward round rnd: x^(rnd-1)
   function automatic logic [7:0] round_const(input int rnd);
      logic [7:0] rc;
      rc = 8'h01;
      for (int i = 1; i < rnd; i++) rc = xtime(rc);
      return rc;
   endfunction

   function automatic round_key_t undo_schedule(input logic [63:0] hi, input logic [63:0] lo,
                                                input logic [3:0] tgt);
      logic [7:0] k [16];
      round_key_t res;
      for (int i = 0; i < 8; i++) begin
         k[i]     = hi[63 - 8*i -: 8];
         k[i + 8] = lo[63 - 8*i -: 8];
      end
      // targets of ten and above leave the key as it came
      for (int rnd = LAST_ROUND; rnd > int'(tgt); rnd--) begin
         for (int j = 15; j >= 4; j--) k[j] ^= k[j - 4];
         k[0] ^= sbox_lut[k[13]] ^ round_const(rnd);
         k[1] ^= sbox_lut[k[14]];
         k[2] ^= sbox_lut[k[15]];
         k[3] ^= sbox_lut[k[12]];
      end
      for (int i = 0; i < 8; i++) begin
         res.hi[63 - 8*i -: 8] = k[i];
         res.lo[63 - 8*i -: 8] = k[i + 8];
      end
      return res;
   endfunction

   task automatic flag(input string what, input round_key_t exp_key);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%s: expected %h %h, got %h %h", what, exp_key.hi, exp_key.lo,
                  rsp_out_hi, rsp_out_lo);
   endtask

   initial begin
      for (int v = 0; v < 256; v++) sbox_lut[v] = sbox_of(v[7:0]);
      // published example key, round 10 back to the cipher key
      known_answer = undo_schedule(64'hD014F9A8C9EE2589, 64'hE13F0CC8B6630CA6, 4'd0);
      if (known_answer !== {64'h2B7E151628AED2A6, 64'hABF7158809CF4F3C}) begin
         known_bad = 1'b1;
         $display("predictor off on known key: got %h %h", known_answer.hi, known_answer.lo);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         target_round = 4'd0;
         mismatches   = known_bad ? 1 : 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_keys.size() == 0) begin
               flag("response with no request pending", '0);
            end else begin
               want = expected_keys.pop_front();
               if (want.hi !== rsp_out_hi || want.lo !== rsp_out_lo)
                  flag("round key mismatch", want);
            end
         end
         if (req_valid && !req_stall)
            expected_keys.push_back(undo_schedule(req_key_hi, req_key_lo, target_round));
         if (csr_wr_en) target_round = csr_wr_data;
         outstanding = expected_keys.size();
      end
   end

endmodule

`default_nettype wire

FILE: dv/aes128_inverse_key_schedule_top_test.sv
// Testbench top for the AES-128 inverse key schedule: clock, reset, request
// stimulus, response stalls and verdict. Uses aes128_inverse_key_schedule_top
// and aes128_inverse_key_schedule_checker.
`default_nettype none

module aes128_inverse_key_schedule_top_test;

   // drain time at the end, longer than the slowest request
   localparam int DRAIN_CYCLES      = 200;
   // long enough for the ring and the output register to both fill
   localparam int HOLD_CYCLES       = 600;
   localparam int ITEMS_PER_SETTING = 81;
   localparam int PHASES            = 4;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [63:0] req_key_hi  = '0;
   logic [63:0] req_key_lo  = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic [63:0] rsp_out_hi;
   logic [63:0] rsp_out_lo;
   logic        csr_wr_en   = 1'b0;
   logic [3:0]  csr_wr_data = '0;

   // idling per phase: none, sender only, receiver only, both lightly
   int send_idle_by_phase [PHASES] = '{0, 63, 0, 17};
   int stall_by_phase     [PHASES] = '{0, 0, 63, 17};
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_req      = 0;   // set by stimulus, picked up once by the stall process
   int hold_left     = 0;
   bit hold_taken    = 1'b0;

   int mismatches;
   int outstanding;
   int phase, blk, n;
   logic [3:0] tgt;

   always #1 clock = ~clock;

   aes128_inverse_key_schedule_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_key_hi  (req_key_hi),
      .req_key_lo  (req_key_lo),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_out_hi  (rsp_out_hi),
      .rsp_out_lo  (rsp_out_lo),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   aes128_inverse_key_schedule_checker key_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_key_hi  (req_key_hi),
      .req_key_lo  (req_key_lo),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_out_hi  (rsp_out_hi),
      .rsp_out_lo  (rsp_out_lo),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // key half: mostly random, now and then all zeros or all ones
   function automatic logic [63:0] pick_half();
      case ($urandom_range(15))
         0: return 64'h0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Offer one request, with random idle cycles ahead of it. Called and
   // returns at a falling edge; valid stays high if the next one follows.
   task automatic offer_key(input logic [63:0] hi, input logic [63:0] lo);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_key_hi <= hi;
      req_key_lo <= lo;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // sender goes quiet until every response is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // target_round is only written with the block empty
   task automatic write_target(input logic [3:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Response side: random stalls, plus a long hold-off on request.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_req != 0 && !hold_taken) begin
            hold_left  = hold_req;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: all the way back to the cipher key on a published example,
      // the all-zero and all-one keys and alternating bit patterns.
      write_target(4'd0);
      offer_key(64'hD014F9A8C9EE2589, 64'hE13F0CC8B6630CA6);
      offer_key(64'h0, 64'h0);
      offer_key('1, '1);
      offer_key(64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555);
      offer_key(64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA);
      // every other target, including ten (no rounds) and the values above it
      for (n = 1; n < 16; n++) begin
         write_target(n[3:0]);
         offer_key(pick_half(), pick_half());
      end

      // Random: four idling phases, four target settings in each
      for (phase = 0; phase < PHASES; phase++) begin
         send_idle_pct = send_idle_by_phase[phase];
         stall_pct     = stall_by_phase[phase];
         for (blk = 0; blk < 4; blk++) begin
            case (blk)
               0: tgt = 4'd0;                           // full ten rounds
               1: tgt = 4'($urandom_range(15));
               2: tgt = 4'd10;                          // pass-through
               default: tgt = 4'($urandom_range(1, 9));
            endcase
            write_target(tgt);
            for (n = 0; n < ITEMS_PER_SETTING; n++) begin
               // receiver holds off while requests keep coming: block backs up
               if (phase == 0 && blk == 1 && n == 20) hold_req = HOLD_CYCLES;
               // sender pauses mid-setting until the pipe is empty
               if (n == 40 && ((phase == 0 && blk == 0) || $urandom_range(2) == 0))
                  wait_drained();
               offer_key(pick_half(), pick_half());
            end
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // hard stop, many times the slowest legal run
   initial begin
      #6000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
design/aesiks_pkg.sv
design/aesiks_byte_ring.sv
design/aes128_inverse_key_schedule_top.sv
design/aesiks_checker.sv
dv/aes128_inverse_key_schedule_checker.sv
dv/aes128_inverse_key_schedule_top_test.sv
